/* rtl/vmd_pkg.sv */
package vmd_pkg;

  localparam logic [15:0] MAGIC_WORD = 16'h464E;

  localparam logic [31:0] MAX_LEN_RST   = 32'd8388608;
  localparam logic [7:0]  VIDEO_TYPE_RST = 8'h10;
  localparam logic [7:0]  SKIP_RST       = 8'd12;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_LEN    = 2'd0,
    REG_VIDEO_TYPE = 2'd1,
    REG_SKIP       = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_VIDEO     = 2'd0,
    KIND_BAD_MAGIC = 2'd1,
    KIND_TOO_LONG  = 2'd2,
    KIND_TOO_SHORT = 2'd3
  } kind_t;

  typedef enum logic {
    PH_HEADER  = 1'b0,
    PH_PAYLOAD = 1'b1
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       key;
    logic       last;
  } res_t;

endpackage

/* rtl/video_message_deframer.sv */
// channel  | direction | handshake             | payload
// in       | input     | in_valid / in_stall   | in_byte
// out      | output    | out_valid / out_stall | out_kind, out_byte, out_is_keyframe,
//          |           |                       | out_frame_last
// cfg      | input     | cfg_wr_en             | cfg_index, cfg_data
//
// One word per clock while in_stall is low: a word is decoded in the cycle it is
// taken; its result (if any) lands in the output or skid register on the same edge.
// A result waiting on out_stall does not stop the input; a second result goes to a
// one-entry skid register, and in_stall is high only while that skid entry is full.
// Synchronous active-low reset; control and config registers return to defaults.
// After an error result the block drops all further words until reset.
module video_message_deframer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_kind,
  output logic [7:0]                        out_byte,
  output logic                              out_is_keyframe,
  output logic                              out_frame_last,
  input  logic                              cfg_wr_en,
  input  logic [vmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [31:0]      max_len_r;
  logic [7:0]       video_type_r;
  logic [7:0]       skip_cfg_r;

  vmd_pkg::phase_t  phase_r, phase_nxt;
  logic [2:0]       hdr_cnt_r, hdr_cnt_nxt;
  logic [55:0]      hdr_sh_r, hdr_sh_nxt;
  logic [31:0]      bytes_left_r, bytes_left_nxt;
  logic [7:0]       skip_left_r, skip_left_nxt;
  logic             is_video_r, is_video_nxt;
  logic             key_r, key_nxt;
  logic             failed_r, failed_nxt;

  logic             in_acc;
  logic             out_acc;
  logic             res_v;
  vmd_pkg::res_t    res;

  logic             out_v_r, out_v_nxt;
  vmd_pkg::res_t    out_r, out_nxt;
  logic             skid_v_r, skid_v_nxt;
  vmd_pkg::res_t    skid_r, skid_nxt;

  logic [63:0]      hdr_word;
  logic [15:0]      hdr_magic;
  logic [7:0]       hdr_type;
  logic [7:0]       hdr_flags;
  logic [31:0]      hdr_len;
  logic             hdr_video;

  assign in_stall = skid_v_r;
  assign in_acc   = in_valid && !skid_v_r;
  assign out_acc  = out_v_r && !out_stall;

  assign hdr_word  = {hdr_sh_r, in_byte};
  assign hdr_magic = hdr_word[63:48];
  assign hdr_type  = hdr_word[47:40];
  assign hdr_flags = hdr_word[39:32];
  assign hdr_len   = hdr_word[31:0];
  assign hdr_video = (hdr_type == video_type_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= vmd_pkg::MAX_LEN_RST;
      video_type_r <= vmd_pkg::VIDEO_TYPE_RST;
      skip_cfg_r   <= vmd_pkg::SKIP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        vmd_pkg::REG_MAX_LEN:    max_len_r    <= cfg_data;
        vmd_pkg::REG_VIDEO_TYPE: video_type_r <= cfg_data[7:0];
        vmd_pkg::REG_SKIP:       skip_cfg_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    hdr_sh_nxt     = hdr_sh_r;
    bytes_left_nxt = bytes_left_r;
    skip_left_nxt  = skip_left_r;
    is_video_nxt   = is_video_r;
    key_nxt        = key_r;
    failed_nxt     = failed_r;
    res_v          = 1'b0;
    res            = '{kind: vmd_pkg::KIND_VIDEO, data: 8'd0, key: 1'b0, last: 1'b0};

    if (in_acc && !failed_r) begin
      case (phase_r)
        vmd_pkg::PH_HEADER: begin
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
          hdr_sh_nxt  = hdr_word[55:0];
          if (hdr_cnt_r == 3'd7) begin
            if (hdr_magic != vmd_pkg::MAGIC_WORD) begin
              failed_nxt = 1'b1;
              res_v      = 1'b1;
              res.kind   = vmd_pkg::KIND_BAD_MAGIC;
            end else if (hdr_len > max_len_r) begin
              failed_nxt = 1'b1;
              res_v      = 1'b1;
              res.kind   = vmd_pkg::KIND_TOO_LONG;
            end else begin
              is_video_nxt = hdr_video;
              key_nxt      = hdr_flags[0];
              if (hdr_video && (hdr_len <= {24'd0, skip_cfg_r})) begin
                failed_nxt = 1'b1;
                res_v      = 1'b1;
                res.kind   = vmd_pkg::KIND_TOO_SHORT;
              end else begin
                bytes_left_nxt = hdr_len;
                skip_left_nxt  = hdr_video ? skip_cfg_r : 8'd0;
                if (hdr_len != 32'd0) begin
                  phase_nxt = vmd_pkg::PH_PAYLOAD;
                end
              end
            end
          end
        end
        vmd_pkg::PH_PAYLOAD: begin
          if (bytes_left_r <= 32'd1) begin
            bytes_left_nxt = 32'd0;
            phase_nxt      = vmd_pkg::PH_HEADER;
          end else begin
            bytes_left_nxt = bytes_left_r - 32'd1;
          end
          if (is_video_r) begin
            if (skip_left_r != 8'd0) begin
              skip_left_nxt = skip_left_r - 8'd1;
            end else begin
              res_v    = 1'b1;
              res.data = in_byte;
              res.key  = key_r;
              res.last = (bytes_left_r == 32'd1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output register with one skid entry behind it
  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (!out_v_r || out_acc) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_nxt   = res;
        out_v_nxt = res_v;
      end
    end else if (res_v) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= vmd_pkg::PH_HEADER;
      hdr_cnt_r    <= 3'd0;
      hdr_sh_r     <= 56'd0;
      bytes_left_r <= 32'd0;
      skip_left_r  <= 8'd0;
      is_video_r   <= 1'b0;
      key_r        <= 1'b0;
      failed_r     <= 1'b0;
      out_v_r      <= 1'b0;
      skid_v_r     <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      hdr_sh_r     <= hdr_sh_nxt;
      bytes_left_r <= bytes_left_nxt;
      skip_left_r  <= skip_left_nxt;
      is_video_r   <= is_video_nxt;
      key_r        <= key_nxt;
      failed_r     <= failed_nxt;
      out_v_r      <= out_v_nxt;
      skid_v_r     <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = out_v_r;
  assign out_kind        = out_r.kind;
  assign out_byte        = out_r.data;
  assign out_is_keyframe = out_r.key;
  assign out_frame_last  = out_r.last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry full while output register empty");

  a_payload_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == vmd_pkg::PH_PAYLOAD) |-> (bytes_left_r != 32'd0))
    else $error("payload phase with no bytes left");

  a_fail_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |=> (failed_r && (phase_r == vmd_pkg::PH_HEADER)))
    else $error("failure state cleared without reset");

  a_error_sets_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v && (res.kind != vmd_pkg::KIND_VIDEO)) |=> failed_r)
    else $error("error word without entering failure state");

endmodule

/* sim/video_message_deframer_tb.sv */
module video_message_deframer_tb;

  localparam logic [vmd_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

  class deframer_check;
    logic [31:0]      max_len;
    logic [7:0]       video_type;
    logic [7:0]       skip_cnt;
    vmd_pkg::phase_t  ph;
    logic [2:0]       hdr_cnt;
    logic [63:0]      hdr;
    logic [31:0]      left;
    logic [7:0]       skip_left;
    logic             is_video;
    logic             key;
    logic             dead;
    vmd_pkg::res_t    expected_words[$];
    int               mismatches;

    function new();
      max_len = vmd_pkg::MAX_LEN_RST;
      video_type = vmd_pkg::VIDEO_TYPE_RST;
      skip_cnt = vmd_pkg::SKIP_RST;
      ph = vmd_pkg::PH_HEADER;
      hdr_cnt = '0;
      hdr = '0;
      left = '0;
      skip_left = '0;
      is_video = 1'b0;
      key = 1'b0;
      dead = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [vmd_pkg::CFG_IDX_W-1:0] idx,
                            logic [vmd_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        vmd_pkg::REG_MAX_LEN: max_len = val;
        vmd_pkg::REG_VIDEO_TYPE: video_type = val[7:0];
        vmd_pkg::REG_SKIP: skip_cnt = val[7:0];
        default: ;
      endcase
    endfunction

    function void push(vmd_pkg::kind_t k, logic [7:0] d, logic kf, logic lst);
      vmd_pkg::res_t r;
      r.kind = k;
      r.data = d;
      r.key = kf;
      r.last = lst;
      expected_words.push_back(r);
    endfunction

    // first error sticks: nothing more comes out until reset
    function void fail(vmd_pkg::kind_t k);
      dead = 1'b1;
      ph = vmd_pkg::PH_HEADER;
      push(k, 8'h00, 1'b0, 1'b0);
    endfunction

    function void take_byte(logic [7:0] b);
      logic [31:0] len;
      logic        lst;
      if (dead) return;
      if (ph == vmd_pkg::PH_HEADER) begin
        hdr = {hdr[55:0], b};
        hdr_cnt = hdr_cnt + 3'd1;
        if (hdr_cnt != 3'd0) return;
        len = hdr[31:0];
        if (hdr[63:48] != vmd_pkg::MAGIC_WORD) begin
          fail(vmd_pkg::KIND_BAD_MAGIC);
          return;
        end
        if (len > max_len) begin
          fail(vmd_pkg::KIND_TOO_LONG);
          return;
        end
        is_video = (hdr[47:40] == video_type);
        key = hdr[32];
        if (is_video && len <= {24'd0, skip_cnt}) begin
          fail(vmd_pkg::KIND_TOO_SHORT);
          return;
        end
        left = len;
        skip_left = is_video ? skip_cnt : 8'd0;
        if (len != 32'd0) ph = vmd_pkg::PH_PAYLOAD;
        return;
      end
      lst = (left == 32'd1);
      left = left - 32'd1;
      if (lst || left == '1) begin
        left = '0;
        ph = vmd_pkg::PH_HEADER;
      end
      if (!is_video) return;
      if (skip_left != 8'd0) begin
        skip_left = skip_left - 8'd1;
        return;
      end
      push(vmd_pkg::KIND_VIDEO, b, key, lst);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task match_word(logic [1:0] k, logic [7:0] d, logic kf, logic lst);
      vmd_pkg::res_t e;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word kind %0d byte %02h", k, d));
        return;
      end
      e = expected_words.pop_front();
      if (k !== e.kind) report($sformatf("kind %0d, expected %0d", k, e.kind));
      if (d !== e.data) report($sformatf("byte %02h, expected %02h", d, e.data));
      if (kf !== e.key) report($sformatf("keyframe %0b, expected %0b", kf, e.key));
      if (lst !== e.last) report($sformatf("frame_last %0b, expected %0b", lst, e.last));
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [7:0]                     in_byte;
  logic                           out_valid;
  logic                           out_stall;
  logic [1:0]                     out_kind;
  logic [7:0]                     out_byte;
  logic                           out_is_keyframe;
  logic                           out_frame_last;
  logic                           cfg_wr_en;
  logic [vmd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vmd_pkg::CFG_DATA_W-1:0] cfg_data;

  bit tx_gaps;
  bit rx_gaps;
  bit hold_out;

  deframer_check sb;

  always #5 clk = ~clk;

  video_message_deframer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_is_keyframe (out_is_keyframe),
    .out_frame_last  (out_frame_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // results first, so a word arriving with an empty queue is never masked
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.match_word(out_kind, out_byte, out_is_keyframe, out_frame_last);
      if (in_valid && !in_stall) sb.take_byte(in_byte);
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
        hold_out = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_hdr(input logic [15:0] magic, input logic [7:0] typ,
                          input logic [7:0] flg, input logic [31:0] len, input int nbytes);
    logic [63:0] h;
    h = {magic, typ, flg, len};
    for (int i = 0; i < nbytes; i++) send_byte(h[63 - 8 * i -: 8]);
  endtask

  task automatic send_payload(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_msg(input logic [15:0] magic, input logic [7:0] typ,
                          input logic [7:0] flg, input logic [31:0] len);
    send_hdr(magic, typ, flg, len, 8);
    send_payload(len);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_words.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [vmd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vmd_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  initial begin
    int             sent;
    int             pick;
    int             len;
    logic [7:0]     typ;
    logic [7:0]     flg;
    logic [7:0]     skp;
    logic [31:0]    mx;
    vmd_pkg::kind_t bad;

    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_byte <= 8'h00;
    cfg_wr_en <= 1'b0;
    cfg_index <= vmd_pkg::REG_MAX_LEN;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    // reset settings: shortest video frame, then flags with bit 0 clear
    send_msg(vmd_pkg::MAGIC_WORD, 8'h10, 8'h01, 32'd13);
    send_msg(vmd_pkg::MAGIC_WORD, 8'h10, 8'hFE, 32'd20);
    // empty non-video message runs straight into the next header
    send_msg(vmd_pkg::MAGIC_WORD, 8'hFF, 8'hFF, 32'd0);
    send_msg(vmd_pkg::MAGIC_WORD, 8'h00, 8'h00, 32'd5);
    settle();
    cfg_write(vmd_pkg::REG_SKIP, 32'd0);
    cfg_write(vmd_pkg::REG_MAX_LEN, 32'd20);
    send_msg(vmd_pkg::MAGIC_WORD, 8'h10, 8'h01, 32'd20);
    send_msg(vmd_pkg::MAGIC_WORD, 8'h10, 8'h00, 32'd1);
    // skip is latched at header end
    send_hdr(vmd_pkg::MAGIC_WORD, 8'h10, 8'h01, 32'd6, 8);
    send_payload(2);
    settle();
    cfg_write(vmd_pkg::REG_SKIP, 32'd255);
    send_payload(4);
    // type and skip are sampled on the last header byte
    send_hdr(vmd_pkg::MAGIC_WORD, 8'h00, 8'h00, 32'd3, 7);
    settle();
    cfg_write(vmd_pkg::REG_VIDEO_TYPE, 32'd0);
    cfg_write(vmd_pkg::REG_SKIP, 32'd1);
    send_byte(8'd3);
    send_payload(3);
    settle();
    cfg_write(vmd_pkg::REG_MAX_LEN, 32'd0);
    send_msg(vmd_pkg::MAGIC_WORD, 8'h55, 8'h80, 32'd0);
    settle();
    cfg_write(vmd_pkg::REG_MAX_LEN, '1);
    cfg_write(REG_NONE, 32'd0);
    send_msg(vmd_pkg::MAGIC_WORD, 8'h00, 8'h01, 32'd4);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: begin
          skp = 8'd0;
          typ = 8'hFF;
          mx = '1;
        end
        1: begin
          skp = 8'd255;
          typ = 8'($urandom_range(0, 255));
          mx = {24'd0, skp} + 32'd40 + $urandom_range(0, 1000);
        end
        default: begin
          skp = 8'($urandom_range(0, 40));
          typ = 8'($urandom_range(0, 255));
          mx = (ph == 3 || $urandom_range(0, 1)) ? '1 :
               {24'd0, skp} + 32'd40 + $urandom_range(0, 1000);
        end
      endcase
      cfg_write(vmd_pkg::REG_MAX_LEN, mx);
      cfg_write(vmd_pkg::REG_VIDEO_TYPE, {24'd0, typ});
      cfg_write(vmd_pkg::REG_SKIP, {24'd0, skp});
      tx_gaps = (ph < 7) && ($urandom_range(0, 3) != 0);
      rx_gaps = (ph < 7) && ($urandom_range(0, 3) != 0);
      sent = 0;
      if (ph == 3) begin
        hold_out = 1'b1;
        send_msg(vmd_pkg::MAGIC_WORD, typ, 8'h01, {24'd0, skp} + 32'd120);
        sent = 8 + skp + 120;
      end
      while (sent < 220) begin
        pick = $urandom_range(0, 19);
        flg = 8'($urandom_range(0, 255));
        if (pick < 15) begin
          len = skp + $urandom_range(1, 40);
          send_msg(vmd_pkg::MAGIC_WORD, typ, flg, len);
        end else begin
          len = (pick == 19) ? 0 : $urandom_range(1, 30);
          send_msg(vmd_pkg::MAGIC_WORD, typ ^ 8'($urandom_range(1, 255)), flg, len);
        end
        sent += 8 + len;
      end
    end

    // one error ends the stream; bytes after it are dropped
    settle();
    flg = 8'($urandom_range(0, 255));
    bad = vmd_pkg::kind_t'($urandom_range(1, 3));
    case (bad)
      vmd_pkg::KIND_BAD_MAGIC:
        send_hdr(vmd_pkg::MAGIC_WORD ^ 16'($urandom_range(1, 65535)),
                 8'($urandom_range(0, 255)), flg, $urandom, 8);
      vmd_pkg::KIND_TOO_LONG: begin
        mx = $urandom_range(0, 5000);
        cfg_write(vmd_pkg::REG_MAX_LEN, mx);
        send_hdr(vmd_pkg::MAGIC_WORD, 8'($urandom_range(0, 255)), flg,
                 mx + 32'd1 + ($urandom & 32'h7FFF_FFFF), 8);
      end
      default:
        send_hdr(vmd_pkg::MAGIC_WORD, sb.video_type, flg,
                 $urandom_range(0, sb.skip_cnt), 8);
    endcase
    send_payload(16);
    in_valid <= 1'b0;

    do @(posedge clk); while (sb.expected_words.size() != 0);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* video_message_deframer.f */
rtl/vmd_pkg.sv
rtl/video_message_deframer.sv
sim/video_message_deframer_tb.sv
